// File: rtl/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

	// Default number of entries the queue can hold.
	localparam int CAPACITY = 128;

	// Payload widths of the request and response channels.
	localparam int DATA_W   = 32;
	localparam int TOTAL_W  = 8;
	localparam int STATUS_W = 2;

	// Operation codes carried in the request.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Status codes returned with each response.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mhpq_if.sv
`default_nettype none

// Request channel: one operation per transaction.
interface mhpq_req_if;
	logic                               valid;
	logic                               ready;
	logic                               cmd;
	logic signed [mhpq_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

// Response channel: one result per request transaction.
interface mhpq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mhpq_pkg::DATA_W-1:0]   top_value;
	logic        [mhpq_pkg::TOTAL_W-1:0]  entry_total;
	logic        [mhpq_pkg::STATUS_W-1:0] status;

	modport source (output valid, output top_value, output entry_total, output status,
		input ready);
	modport sink (input valid, input top_value, input entry_total, input status,
		output ready);
endinterface

`default_nettype wire

// File: rtl/max_heap_priority_queue.sv
// A response is registered and appears in the cycle after its request transaction.
// Throughput: one transaction per cycle unless a response stalls; each
// operation updates the whole chain at once, with one comparator per cell.
// A new request is taken only in a cycle where no response is pending or the
// pending one is being read, so a stalled response holds off the input.
// Reset (arst_n low) empties the queue and drops any pending response.
`default_nettype none

module max_heap_priority_queue #(
	parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
	input  wire         clk,
	input  wire         arst_n,
	mhpq_req_if.sink    req,
	mhpq_rsp_if.source  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = mhpq_pkg::DATA_W;

	logic signed [DW-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]  cell_occ;
	logic [CAPACITY-1:0]  cell_take;

	logic [CW-1:0]        count_q;
	logic                 full;
	logic                 empty;
	logic                 accept;
	mhpq_pkg::cell_ctrl_t ctrl;

	logic signed [DW-1:0] next_top;
	logic [CW-1:0]        next_count;
	mhpq_pkg::status_t    next_status;
	logic [CW+7:0]        count_ext;

	logic                  rsp_valid_q;
	logic signed [DW-1:0]  top_q;
	logic [mhpq_pkg::TOTAL_W-1:0] total_q;
	mhpq_pkg::status_t     status_q;

	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	// Command broadcast; refused operations leave the chain untouched.
	assign ctrl.ins = accept && (req.cmd == mhpq_pkg::OP_INSERT) && !full;
	assign ctrl.rem = accept && (req.cmd == mhpq_pkg::OP_REMOVE) && !empty;

	// The chain of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DW-1:0] l_data;
		logic                 l_occ;
		logic                 l_take;
		logic signed [DW-1:0] r_data;
		logic                 r_occ;

		if (i == 0) begin : g_head
			assign l_data = '0;
			assign l_occ  = 1'b0;
			assign l_take = 1'b0;
		end else begin : g_mid_l
			assign l_data = cell_data[i-1];
			assign l_occ  = cell_occ[i-1];
			assign l_take = cell_take[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_data = '0;
			assign r_occ  = 1'b0;
		end else begin : g_mid_r
			assign r_data = cell_data[i+1];
			assign r_occ  = cell_occ[i+1];
		end

		mhpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (req.value),
			.left_data  (l_data),
			.left_occ   (l_occ),
			.left_take  (l_take),
			.right_data (r_data),
			.right_occ  (r_occ),
			.data_q     (cell_data[i]),
			.occ_q      (cell_occ[i]),
			.take       (cell_take[i])
		);
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.rem) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result of the operation, formed from the state before the update.
	always_comb begin
		next_top    = cell_occ[0] ? cell_data[0] : '0;
		next_count  = count_q;
		next_status = mhpq_pkg::ST_DONE;
		unique case (req.cmd)
			mhpq_pkg::OP_INSERT: begin
				if (full) begin
					next_status = mhpq_pkg::ST_OVERFLOW;
				end else begin
					next_count = count_q + CW'(1);
					if (!cell_occ[0] || (req.value > cell_data[0])) begin
						next_top = req.value;
					end
				end
			end
			mhpq_pkg::OP_REMOVE: begin
				if (empty) begin
					next_status = mhpq_pkg::ST_UNDERFLOW;
				end else begin
					next_count = count_q - CW'(1);
					next_top   = cell_occ[1] ? cell_data[1] : '0;
				end
			end
			default: begin
				next_status = mhpq_pkg::ST_DONE;
			end
		endcase
	end

	// Count is reported modulo 256.
	assign count_ext = {8'd0, next_count};

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= next_top;
			total_q  <= count_ext[7:0];
			status_q <= next_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.top_value   = top_q;
	assign rsp.entry_total = total_q;
	assign rsp.status      = status_q;

	// Occupied cells match the entry count.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == 32'(count_q))
		else $error("cell occupancy disagrees with entry count");

	// The count never passes the capacity.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The head holds the largest value.
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		cell_occ[1] |-> (cell_data[0] >= cell_data[1]))
		else $error("head cell is not the maximum");

	// A remove on an empty queue reports underflow and an empty result.
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == mhpq_pkg::OP_REMOVE) && empty) |=>
		(rsp_valid_q && (status_q == mhpq_pkg::ST_UNDERFLOW) && (top_q == '0)))
		else $error("underflow not reported");

endmodule

`default_nettype wire

// File: rtl/mhpq_cell.sv
`default_nettype none

// One slot of the sorted chain. Cell 0 holds the maximum; values fall
// off in non-increasing order toward the tail, and occupied cells form
// a contiguous prefix.
module mhpq_cell (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire mhpq_pkg::cell_ctrl_t          ctrl,
	input  wire logic signed [mhpq_pkg::DATA_W-1:0] new_value,
	// Neighbor toward the head.
	input  wire logic signed [mhpq_pkg::DATA_W-1:0] left_data,
	input  wire                                left_occ,
	input  wire                                left_take,
	// Neighbor toward the tail.
	input  wire logic signed [mhpq_pkg::DATA_W-1:0] right_data,
	input  wire                                right_occ,
	// Own state and insert decision.
	output logic signed [mhpq_pkg::DATA_W-1:0] data_q,
	output logic                               occ_q,
	output logic                               take
);

	// The new value belongs here if the slot is free or holds a smaller value.
	assign take = !occ_q || (new_value > data_q);

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.rem) begin
			occ_q <= right_occ;
		end else if (ctrl.ins) begin
			if (left_take) begin
				occ_q <= left_occ;
			end else if (take) begin
				occ_q <= 1'b1;
			end
		end
	end

	// Stored value: shifts toward the tail on insert, toward the head on remove.
	always_ff @(posedge clk) begin
		if (ctrl.rem) begin
			data_q <= right_data;
		end else if (ctrl.ins) begin
			if (left_take) begin
				data_q <= left_data;
			end else if (take) begin
				data_q <= new_value;
			end
		end
	end

endmodule

`default_nettype wire
